>>> src/olp_pkg.sv
package olp_pkg;

  // payload and register widths
  localparam int VALUE_W     = 32;
  localparam int BARRIER_W   = 32;
  localparam int STEPS_W     = 7;
  localparam int LIMIT_W     = 7;
  localparam int SPREAD_W    = 31;
  localparam int DRIFT_W     = 32;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // 1.0 in unsigned q1.31
  localparam logic [VALUE_W-1:0] UNITY = 32'h8000_0000;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_STEPS    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LIMIT    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_DISCOUNT = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPREAD   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_DRIFT    = 3'd4;

  // register reset values
  localparam logic [STEPS_W-1:0]  STEPS_RST    = 7'd64;
  localparam logic [LIMIT_W-1:0]  LIMIT_RST    = 7'd33;
  localparam logic [VALUE_W-1:0]  DISCOUNT_RST = 32'h8000_0000;
  localparam logic [SPREAD_W-1:0] SPREAD_RST   = 31'd16777216;
  localparam logic [DRIFT_W-1:0]  DRIFT_RST    = 32'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_SETUP,
    ST_WALK,
    ST_DRAIN,
    ST_READ,
    ST_RESULT
  } olp_state_t;

endpackage

>>> src/olp_if.sv
interface olp_barrier_if;
  import olp_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [BARRIER_W-1:0] log_barrier;

  modport source (output valid, output log_barrier, input ready);
  modport sink (input valid, input log_barrier, output ready);
endinterface

interface olp_value_if;
  import olp_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] lattice_value;

  modport source (output valid, output lattice_value, input ready);
  modport sink (input valid, input lattice_value, output ready);
endinterface

>>> src/olp_layer_ram.sv
module olp_layer_ram #(
  parameter int DEPTH  = 16770,
  parameter int ADDR_W = 15
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [ADDR_W-1:0]           waddr,
  input  logic [olp_pkg::VALUE_W-1:0] wdata,
  input  logic [ADDR_W-1:0]           raddr_a,
  input  logic [ADDR_W-1:0]           raddr_b,
  output logic [olp_pkg::VALUE_W-1:0] rdata_a,
  output logic [olp_pkg::VALUE_W-1:0] rdata_b
);
  import olp_pkg::*;

  logic [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> src/olp_node_mac.sv
module olp_node_mac #(
  parameter int ADDR_W = 15
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        issue_valid,
  input  logic [ADDR_W-1:0]           issue_addr,
  input  logic [olp_pkg::VALUE_W-1:0] child_up,
  input  logic [olp_pkg::VALUE_W-1:0] child_dn,
  input  logic [olp_pkg::VALUE_W-1:0] discount_factor,
  output logic                        wr_en,
  output logic [ADDR_W-1:0]           wr_addr,
  output logic [olp_pkg::VALUE_W-1:0] wr_data,
  output logic                        busy
);
  import olp_pkg::*;

  // stage 1 lines up with the ram read data, stage 2 holds the sum,
  // stage 3 holds the product
  logic                 vld1, vld2, vld3;
  logic [ADDR_W-1:0]    addr1, addr2, addr3;
  logic [VALUE_W:0]     child_sum;
  logic [2*VALUE_W:0]   product;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
    end else begin
      vld1 <= issue_valid;
      vld2 <= vld1;
      vld3 <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    addr1     <= issue_addr;
    addr2     <= addr1;
    addr3     <= addr2;
    child_sum <= {1'b0, child_up} + {1'b0, child_dn};
    product   <= child_sum * discount_factor;
  end

  // sum <= 2.0 and discount <= 1.0, so the top product bit stays clear
  assign wr_en   = vld3;
  assign wr_addr = addr3;
  assign wr_data = product[2*VALUE_W-1:VALUE_W];
  assign busy    = vld1 | vld2 | vld3;

endmodule

>>> src/olp_walker.sv
module olp_walker #(
  parameter int MAX_STEPS = 64,
  parameter int ADDR_W    = 15
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [olp_pkg::BARRIER_W-1:0] log_barrier,
  input  logic [olp_pkg::STEPS_W-1:0]         steps_in_use,
  input  logic [olp_pkg::LIMIT_W-1:0]         occupation_limit,
  input  logic [olp_pkg::SPREAD_W-1:0]        spread_step,
  input  logic signed [olp_pkg::DRIFT_W-1:0]  drift_step,
  input  logic                                mac_busy,
  input  logic                                out_free,
  output logic                                idle,
  output logic                                issue_valid,
  output logic [ADDR_W-1:0]                   issue_addr,
  output logic [ADDR_W-1:0]                   raddr_a,
  output logic [ADDR_W-1:0]                   raddr_b,
  output logic                                fill_we,
  output logic [ADDR_W-1:0]                   fill_addr,
  output logic [olp_pkg::VALUE_W-1:0]         fill_data,
  output logic                                result_load
);
  import olp_pkg::*;

  localparam int ROW_LEN   = 2 * MAX_STEPS + 1;
  localparam int LAYER_LEN = (MAX_STEPS + 1) * ROW_LEN;
  localparam int TIME_W    = $clog2(MAX_STEPS + 1);
  localparam int COL_W     = $clog2(ROW_LEN);
  localparam int POS_W     = VALUE_W + TIME_W + 2;
  localparam int CMP_W     = (TIME_W > STEPS_W) ? TIME_W : STEPS_W;

  localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(ROW_LEN);
  localparam logic [ADDR_W-1:0] LAYER_OFS = ADDR_W'(LAYER_LEN);
  localparam logic [ADDR_W-1:0] CENTER    = ADDR_W'(MAX_STEPS);
  localparam logic [ADDR_W-1:0] ONE       = ADDR_W'(1);

  olp_state_t state, state_next;

  logic [TIME_W-1:0]        time_index;
  logic [TIME_W-1:0]        count_index;
  logic [COL_W-1:0]         position_index;
  logic                     layer_select;
  logic [ADDR_W-1:0]        node_abs;
  logic [ADDR_W-1:0]        row_start;
  logic signed [POS_W-1:0]  layer_pos;
  logic signed [POS_W-1:0]  row_dn, row_up;
  logic signed [POS_W-1:0]  pos_dn, pos_up;
  logic signed [POS_W-1:0]  step_diff;
  logic signed [BARRIER_W-1:0] barrier;

  logic signed [POS_W-1:0]  dw_ext, du_ext, bar_ext;
  logic [CMP_W-1:0]         steps_ext;
  logic [TIME_W-1:0]        steps_eff;
  logic [COL_W-1:0]         span;
  logic                     row_end, layer_end, up_hit, dn_hit, fill_drift;
  logic [ADDR_W-1:0]        layer_base, next_row, first_node;

  assign dw_ext  = {{(POS_W - SPREAD_W){1'b0}}, spread_step};
  assign du_ext  = {{(POS_W - DRIFT_W){drift_step[DRIFT_W-1]}}, drift_step};
  assign bar_ext = {{(POS_W - BARRIER_W){barrier[BARRIER_W-1]}}, barrier};

  // step count clamped to 1..MAX_STEPS
  assign steps_ext = CMP_W'(steps_in_use);
  always_comb begin
    if (steps_ext == '0) begin
      steps_eff = TIME_W'(1);
    end else if (steps_ext > CMP_W'(MAX_STEPS)) begin
      steps_eff = TIME_W'(MAX_STEPS);
    end else begin
      steps_eff = steps_ext[TIME_W-1:0];
    end
  end

  assign span       = COL_W'({time_index, 1'b0});
  assign row_end    = (position_index == span);
  assign layer_end  = row_end && (count_index == time_index);
  assign layer_base = layer_select ? LAYER_OFS : '0;
  assign next_row   = row_start + ROW_STEP;
  assign first_node = layer_base + CENTER - ADDR_W'(time_index);
  assign fill_drift = ({1'b0, count_index} + (TIME_W + 1)'(1)) < {1'b0, time_index};

  // barrier test for both children, parent time folded into the accumulators
  assign up_hit = (pos_up <= bar_ext);
  assign dn_hit = (pos_dn <= bar_ext);

  assign idle       = (state == ST_IDLE);
  assign issue_addr = layer_select ? node_abs - LAYER_OFS : node_abs + LAYER_OFS;
  assign fill_addr  = node_abs;
  assign fill_data  = (CMP_W'(count_index) < CMP_W'(occupation_limit)) ? UNITY : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    issue_valid = 1'b0;
    fill_we     = 1'b0;
    result_load = 1'b0;
    raddr_a     = node_abs + (up_hit ? ROW_STEP + ONE : ONE);
    raddr_b     = node_abs + (dn_hit ? ROW_STEP - ONE : '1);
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_FILL;
        end
      end
      ST_FILL: begin
        fill_we = 1'b1;
        if (layer_end) begin
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_next = ST_WALK;
      end
      ST_WALK: begin
        issue_valid = 1'b1;
        if (layer_end) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!mac_busy) begin
          state_next = (time_index == '0) ? ST_READ : ST_SETUP;
        end
      end
      ST_READ: begin
        raddr_a    = layer_base + CENTER;
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        raddr_a = layer_base + CENTER;
        if (out_free) begin
          result_load = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_index     <= '0;
      count_index    <= '0;
      position_index <= '0;
      layer_select   <= 1'b0;
    end else begin
      unique case (state) inside
        ST_IDLE: begin
          if (start) begin
            time_index     <= steps_eff;
            count_index    <= '0;
            position_index <= '0;
            layer_select   <= 1'b0;
            node_abs       <= CENTER - ADDR_W'(steps_eff);
            row_start      <= CENTER - ADDR_W'(steps_eff);
            layer_pos      <= '0;
            step_diff      <= du_ext - dw_ext;
            barrier        <= log_barrier;
          end
        end
        ST_FILL, ST_WALK: begin
          node_abs       <= node_abs + ONE;
          position_index <= position_index + COL_W'(1);
          pos_dn         <= pos_dn + dw_ext;
          pos_up         <= pos_up + dw_ext;
          if (row_end) begin
            position_index <= '0;
            count_index    <= count_index + TIME_W'(1);
            row_start      <= next_row;
            node_abs       <= next_row;
            pos_dn         <= row_dn;
            pos_up         <= row_up;
            // build (drift - spread) * (steps - 1) one row at a time
            if (state == ST_FILL && fill_drift) begin
              layer_pos <= layer_pos + step_diff;
            end
            if (layer_end) begin
              count_index <= '0;
              if (state == ST_FILL) begin
                time_index <= time_index - TIME_W'(1);
              end
            end
          end
        end
        ST_SETUP: begin
          row_start <= first_node;
          node_abs  <= first_node;
          pos_dn    <= layer_pos - dw_ext;
          row_dn    <= layer_pos - dw_ext;
          pos_up    <= layer_pos + dw_ext;
          row_up    <= layer_pos + dw_ext;
        end
        ST_DRAIN: begin
          if (!mac_busy) begin
            layer_select <= !layer_select;
            if (time_index != '0) begin
              time_index <= time_index - TIME_W'(1);
              layer_pos  <= layer_pos - step_diff;
            end
          end
        end
        ST_RESULT: begin
          if (out_free) begin
            layer_select <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> src/occupation_lattice_pricer_unit.sv
// occupation-time barrier pricer: each transaction on barrier carries one log barrier
// level, and one root value comes back on price after backward induction over a binomial
// lattice of (occupation count, position) nodes. for m active steps an item first fills
// (m+1)(2m+1) nodes, then for each layer i = m-1 down to 0 runs a setup state, walks
// (i+1)(2i+1) nodes and waits in a drain state, then reads the root. within a layer the
// walk runs at one node per cycle through the single multiply-add unit, fed by the two
// read ports of the layer ram. barrier.ready is high only while no item is in work; a
// finished value may still wait on price while the next item is taken. configuration
// must be written only while idle; the block itself does not enforce it. the layer ram
// needs no clearing: every entry read is written earlier in the same item.
module occupation_lattice_pricer_unit #(
  parameter int MAX_STEPS = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  olp_barrier_if.sink                       barrier,
  olp_value_if.source                       price,
  input  logic                              cfg_write,
  input  logic [olp_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [olp_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import olp_pkg::*;

  // two layers of (MAX_STEPS+1) count rows by (2*MAX_STEPS+1) positions
  localparam int ROW_LEN   = 2 * MAX_STEPS + 1;
  localparam int LAYER_LEN = (MAX_STEPS + 1) * ROW_LEN;
  localparam int MEM_DEPTH = 2 * LAYER_LEN;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  // configuration registers
  logic [STEPS_W-1:0]        steps_in_use;
  logic [LIMIT_W-1:0]        occupation_limit;
  logic [VALUE_W-1:0]        discount_factor;
  logic [SPREAD_W-1:0]       spread_step;
  logic signed [DRIFT_W-1:0] drift_step;

  // result register
  logic               out_valid;
  logic [VALUE_W-1:0] out_value;

  // walker to ram and multiply-add unit
  logic               start, idle, out_free, result_load;
  logic               issue_valid;
  logic [ADDR_W-1:0]  issue_addr;
  logic [ADDR_W-1:0]  raddr_a, raddr_b;
  logic               fill_we;
  logic [ADDR_W-1:0]  fill_addr;
  logic [VALUE_W-1:0] fill_data;
  logic [VALUE_W-1:0] rdata_a, rdata_b;
  logic               mac_we, mac_busy;
  logic [ADDR_W-1:0]  mac_addr;
  logic [VALUE_W-1:0] mac_data;

  // ram write port is shared: fill sweep first, node results later, never both
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [VALUE_W-1:0] ram_wdata;

  // register writes; the discount is saturated to 1.0 as it is stored
  always_ff @(posedge clk) begin
    if (rst) begin
      steps_in_use     <= STEPS_RST;
      occupation_limit <= LIMIT_RST;
      discount_factor  <= DISCOUNT_RST;
      spread_step      <= SPREAD_RST;
      drift_step       <= DRIFT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_STEPS:    steps_in_use     <= cfg_data[STEPS_W-1:0];
        CFG_LIMIT:    occupation_limit <= cfg_data[LIMIT_W-1:0];
        CFG_DISCOUNT: discount_factor  <= (cfg_data > UNITY) ? UNITY : cfg_data;
        CFG_SPREAD:   spread_step      <= cfg_data[SPREAD_W-1:0];
        CFG_DRIFT:    drift_step       <= cfg_data[DRIFT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input side: take a new item only when the walker is parked
  assign barrier.ready = idle;
  assign start         = barrier.valid && barrier.ready;

  // output slot can take the root value when empty or draining this cycle
  assign out_free = !out_valid || price.ready;

  olp_walker #(
    .MAX_STEPS (MAX_STEPS),
    .ADDR_W    (ADDR_W)
  ) u_walker (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .log_barrier      (barrier.log_barrier),
    .steps_in_use     (steps_in_use),
    .occupation_limit (occupation_limit),
    .spread_step      (spread_step),
    .drift_step       (drift_step),
    .mac_busy         (mac_busy),
    .out_free         (out_free),
    .idle             (idle),
    .issue_valid      (issue_valid),
    .issue_addr       (issue_addr),
    .raddr_a          (raddr_a),
    .raddr_b          (raddr_b),
    .fill_we          (fill_we),
    .fill_addr        (fill_addr),
    .fill_data        (fill_data),
    .result_load      (result_load)
  );

  assign ram_we    = fill_we | mac_we;
  assign ram_waddr = fill_we ? fill_addr : mac_addr;
  assign ram_wdata = fill_we ? fill_data : mac_data;

  olp_layer_ram #(
    .DEPTH  (MEM_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // one node per cycle: (up + down) * discount / 2^32
  olp_node_mac #(
    .ADDR_W (ADDR_W)
  ) u_mac (
    .clk             (clk),
    .rst             (rst),
    .issue_valid     (issue_valid),
    .issue_addr      (issue_addr),
    .child_up        (rdata_a),
    .child_dn        (rdata_b),
    .discount_factor (discount_factor),
    .wr_en           (mac_we),
    .wr_addr         (mac_addr),
    .wr_data         (mac_data),
    .busy            (mac_busy)
  );

  // root value lands in the output register straight from read port a
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result_load) begin
      out_valid <= 1'b1;
    end else if (price.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      out_value <= rdata_a;
    end
  end

  assign price.valid         = out_valid;
  assign price.lattice_value = out_value;

endmodule

>>> src/olp_checker.sv
module olp_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [olp_pkg::VALUE_W-1:0] lattice_value
);
  import olp_pkg::*;

  // an accepted item keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after a transaction");

  // a root value never exceeds 1.0
  a_value_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> lattice_value <= UNITY)
    else $error("result above unity");

  // a waiting result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(lattice_value))
    else $error("result dropped or changed while stalled");

  // reset empties the result slot
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind occupation_lattice_pricer_unit olp_checker u_olp_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (barrier.valid),
  .in_ready      (barrier.ready),
  .out_valid     (price.valid),
  .out_ready     (price.ready),
  .lattice_value (price.lattice_value)
);
